FILE: rtl/vpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg: shared types, constants and duration tables
// Widths, command codes and the fixed on/off duration tables of the
// vibration pattern player.
// ----------------------------------------------------------------------------
package vpp_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned PAT_W  = 2;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DUR_W  = 10;

  // Command codes carried by the func field
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_e;

  // Pattern numbers; any other select value plays pattern 0
  localparam logic [PAT_W-1:0] PAT_SHORT = 2'd0;
  localparam logic [PAT_W-1:0] PAT_LONG  = 2'd1;
  localparam logic [PAT_W-1:0] PAT_SLOW  = 2'd2;

  localparam int unsigned PAT0_LEN = 4;
  localparam int unsigned PAT1_LEN = 6;
  localparam int unsigned PAT2_LEN = 2;

  localparam logic [DUR_W-1:0] PAT0_TAB [PAT0_LEN] = '{10'd200, 10'd200, 10'd200, 10'd800};
  localparam logic [DUR_W-1:0] PAT1_TAB [PAT1_LEN] =
    '{10'd400, 10'd200, 10'd400, 10'd200, 10'd400, 10'd800};
  localparam logic [DUR_W-1:0] PAT2_TAB [PAT2_LEN] = '{10'd800, 10'd400};

  // Number of steps in a pattern
  function automatic logic [STEP_W-1:0] pat_len(input logic [PAT_W-1:0] pat);
    logic [STEP_W-1:0] len;
    case (pat)
      PAT_LONG: len = STEP_W'(PAT1_LEN);
      PAT_SLOW: len = STEP_W'(PAT2_LEN);
      default:  len = STEP_W'(PAT0_LEN);
    endcase
    return len;
  endfunction

  // Duration of one step; a step past the end reads the first entry
  function automatic logic [DUR_W-1:0] pat_dur(input logic [PAT_W-1:0]  pat,
                                               input logic [STEP_W-1:0] step);
    logic [DUR_W-1:0] dur;
    logic [STEP_W-1:0] s;
    s = (step >= pat_len(pat)) ? '0 : step;
    case (pat)
      PAT_LONG: dur = PAT1_TAB[s];
      PAT_SLOW: dur = PAT2_TAB[s[0]];
      default:  dur = PAT0_TAB[s[1:0]];
    endcase
    return dur;
  endfunction

  // Result payload
  typedef struct packed {
    logic motor_on;
    logic running;
  } result_t;

endpackage

FILE: rtl/vpp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_if: item channels of the vibration pattern player
// Valid/ready channels for command items and for result items.
// ----------------------------------------------------------------------------
interface vpp_in_if import vpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PAT_W-1:0]  pattern_sel;
  logic              repeat_flag;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, func, pattern_sel, repeat_flag, now_ms, input ready);
  modport sink   (input valid, func, pattern_sel, repeat_flag, now_ms, output ready);
endinterface

interface vpp_out_if import vpp_pkg::*; ();
  logic valid;
  logic ready;
  logic motor_on;
  logic running;

  modport source (output valid, motor_on, running, input ready);
  modport sink   (input valid, motor_on, running, output ready);
endinterface

FILE: rtl/vibration_pattern_player_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vibration_pattern_player_unit: vibration motor pattern sequencer
// Plays one of three fixed on/off duration patterns on a motor drive level,
// driven by start, stop and tick command items that carry the time in ms.
// ----------------------------------------------------------------------------
// Usage: the block takes one command item per clock cycle while the result
// side is ready, and gives exactly one result item for each: every item
// passes an input register, then the pattern logic (a 32-bit deadline
// compare, a duration table read and a 32-bit add) that updates the player
// state and loads the result register. A stalled result holds the pipeline;
// the input register still takes one item while the result waits. Deadlines
// compare as plain unsigned values, so a time counter wrap is not handled.
module vibration_pattern_player_unit import vpp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  vpp_in_if.sink    in_i,
  vpp_out_if.source out_o
);

  // Input register
  logic              in_vld_q;
  logic [FUNC_W-1:0] in_func_q;
  logic [PAT_W-1:0]  in_sel_q;
  logic              in_rep_q;
  logic [TIME_W-1:0] in_now_q;

  // Player state
  logic              active_q, active_d;
  logic              repeat_q, repeat_d;
  logic [PAT_W-1:0]  pat_q, pat_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              drive_q, drive_d;
  logic [TIME_W-1:0] deadline_q, deadline_d;

  // Result register
  logic              out_vld_q;
  result_t           res_q;

  logic              proc_fire;
  logic              in_take;
  logic [STEP_W-1:0] step_inc;
  logic              due;

  assign proc_fire = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || proc_fire;
  assign in_take = in_i.valid && in_i.ready;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= in_i.func;
      in_sel_q  <= in_i.pattern_sel;
      in_rep_q  <= in_i.repeat_flag;
      in_now_q  <= in_i.now_ms;
    end
  end

  assign step_inc = step_q + STEP_W'(1);
  assign due      = active_q && (in_now_q >= deadline_q);

  // Advance the pattern for one command
  always_comb begin
    active_d   = active_q;
    repeat_d   = repeat_q;
    pat_d      = pat_q;
    step_d     = step_q;
    drive_d    = drive_q;
    deadline_d = deadline_q;
    case (in_func_q)
      FUNC_START: begin
        active_d   = 1'b1;
        repeat_d   = in_rep_q;
        pat_d      = in_sel_q;
        step_d     = '0;
        drive_d    = 1'b1;
        deadline_d = in_now_q;
      end
      FUNC_STOP: begin
        active_d = 1'b0;
        drive_d  = 1'b0;
      end
      FUNC_TICK: begin
        if (due) begin
          if (step_inc >= pat_len(pat_q)) begin
            // Last step passed: wrap around or drop out
            step_d = step_inc;
            if (repeat_q) begin
              step_d     = '0;
              drive_d    = 1'b1;
              deadline_d = in_now_q + TIME_W'(pat_dur(pat_q, '0));
            end else begin
              active_d   = 1'b0;
              drive_d    = 1'b0;
              deadline_d = in_now_q + TIME_W'(pat_dur(pat_q, step_q));
            end
          end else begin
            step_d     = step_inc;
            drive_d    = !drive_q;
            deadline_d = in_now_q + TIME_W'(pat_dur(pat_q, step_q));
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Update state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      repeat_q   <= 1'b0;
      pat_q      <= '0;
      step_q     <= '0;
      drive_q    <= 1'b0;
      deadline_q <= '0;
    end else if (proc_fire) begin
      active_q   <= active_d;
      repeat_q   <= repeat_d;
      pat_q      <= pat_d;
      step_q     <= step_d;
      drive_q    <= drive_d;
      deadline_q <= deadline_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q.motor_on <= drive_d;
      res_q.running  <= active_d;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.motor_on = res_q.motor_on;
  assign out_o.running  = res_q.running;

endmodule

FILE: rtl/vpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_checker: port-level checks for the vibration pattern player
// Watches the item channels of the top level and flags timing and
// consistency errors in the result stream.
// ----------------------------------------------------------------------------
module vpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic motor_on_i,
  input logic running_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Motor never drives while no pattern is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (running_i || !motor_on_i))
    else $error("motor driven while idle");

  // A fresh result item follows an accepted item through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 2))
    else $error("result item without a matching accepted item");

  // A stalled result item holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(motor_on_i) && $stable(running_i)))
    else $error("stalled result item changed");

endmodule

bind vibration_pattern_player_unit vpp_checker u_vpp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .motor_on_i (out_o.motor_on),
  .running_i  (out_o.running)
);
